>>> sv/ppg_pkg.sv
`timescale 1ns / 1ps

package ppg_pkg;

    // Sine table: quarter wave, SIN_DEPTH + 1 entries
    localparam int SIN_ABITS = 10;
    localparam int SIN_DEPTH = 1 << SIN_ABITS;

    // Low bits of column and row that take part
    localparam int COORD_BITS = 12;
    localparam logic [11:0] COORD_MASK = 12'((1 << COORD_BITS) - 1);

    // Phase width: Q16 time plus a Q8.16 coordinate term
    localparam int PH_W = 34;
    localparam int SINE_W = 18;

    // Square root operand and result
    localparam int SQ_W = 48;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam logic [SQ_W-1:0] SQ_BIAS = SQ_W'(64'h1_0000_0000);

    // Coordinate divider: quotient bits and saturation
    localparam int Q_BITS = 24;
    localparam logic [20:0] COORD_SCALE = 21'd1310720;
    localparam logic [Q_BITS-1:0] COORD_OFS = 24'd1310720;
    localparam logic [Q_BITS-1:0] Q_SAT = 24'd9699327;
    localparam logic signed [Q_BITS-1:0] COORD_MAX = 24'sd8388607;

    // Unit latencies in enabled cycles
    localparam int L_DIV = Q_BITS + 2;
    localparam int L_SIN = 4;
    localparam int L_SQRT = SQ_STEPS;

    localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] GREEN_TURN = 32'd1417339208;
    localparam logic [31:0] BLUE_TURN = 32'd2834678415;
    localparam logic [14:0] T33_MUL = 15'd21627;

    typedef enum logic [2:0]
    {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_INTERACTIVE  = 3'd2,
        REG_POINTER_X    = 3'd3,
        REG_POINTER_Y    = 3'd4
    } cfg_reg_t;

    typedef logic [16:0] sin_tab_t [0:SIN_DEPTH];

    // Quotient by shift and subtract, one bit per step
    function automatic longint unsigned div_shift_sub(longint unsigned n,
                                                      longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q30 Taylor series, rounded to Q16
    function automatic sin_tab_t sin_tab_build();
        sin_tab_t tab;
        longint unsigned x;
        longint unsigned term;
        longint unsigned den;
        longint sum;
        longint r;
        for (int i = 0; i <= SIN_DEPTH; i++)
        begin
            x = (HALF_PI_Q30 * longint'(i)) / SIN_DEPTH;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                den = longint'((2 * k) * (2 * k + 1));
                term = div_shift_sub(term, den);
                if ((k % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            r = (sum < 0) ? 0 : ((sum + 8192) >>> 14);
            if (r > 65536)
                r = 65536;
            tab[i] = 17'(r);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = sin_tab_build();

endpackage

>>> sv/ppg_div.sv
`timescale 1ns / 1ps

module ppg_div
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [11:0]                          idx,
    input  logic [12:0]                          span,
    output logic signed [ppg_pkg::Q_BITS-1:0]    coord
);
    import ppg_pkg::*;

    logic [32:0]         num_reg;
    logic [12:0]         den_reg;
    logic [32:0]         num_prod;

    logic [12:0]         rem_reg  [0:Q_BITS-1];
    logic [Q_BITS-1:0]   quo_reg  [0:Q_BITS-1];
    logic [Q_BITS-1:0]   nlo_reg  [0:Q_BITS-1];
    logic [12:0]         dv_reg   [0:Q_BITS-1];
    logic [Q_BITS-1:0]   ovf_reg;

    logic [12:0]         rem_next [0:Q_BITS-1];
    logic [Q_BITS-1:0]   quo_next [0:Q_BITS-1];
    logic [Q_BITS-1:0]   nlo_next [0:Q_BITS-1];
    logic [12:0]         dv_next  [0:Q_BITS-1];
    logic [Q_BITS-1:0]   ovf_next;

    logic signed [Q_BITS-1:0] coord_reg;
    logic signed [Q_BITS-1:0] coord_next;

    assign num_prod = 33'(idx) * 33'(COORD_SCALE);

    // One quotient bit per stage; overflow means the quotient needs more than Q_BITS
    always_comb
    begin
        logic [12:0]       rem_i;
        logic [Q_BITS-1:0] quo_i;
        logic [Q_BITS-1:0] nlo_i;
        logic [12:0]       d_i;
        logic              ovf_i;
        logic [13:0]       trial;
        logic              ge;
        for (int k = 0; k < Q_BITS; k++)
        begin
            if (k == 0)
            begin
                rem_i = {4'b0, num_reg[32:24]};
                quo_i = '0;
                nlo_i = num_reg[Q_BITS-1:0];
                d_i   = den_reg;
                ovf_i = ({4'b0, num_reg[32:24]} >= den_reg);
            end
            else
            begin
                rem_i = rem_reg[k-1];
                quo_i = quo_reg[k-1];
                nlo_i = nlo_reg[k-1];
                d_i   = dv_reg[k-1];
                ovf_i = ovf_reg[k-1];
            end
            trial = {rem_i, nlo_i[Q_BITS-1-k]};
            ge = (trial >= {1'b0, d_i});
            rem_next[k] = ge ? 13'(trial - {1'b0, d_i}) : trial[12:0];
            quo_next[k] = {quo_i[Q_BITS-2:0], ge};
            nlo_next[k] = nlo_i;
            dv_next[k]  = d_i;
            ovf_next[k] = ovf_i;
        end
    end

    always_comb
    begin
        if (ovf_reg[Q_BITS-1] || (quo_reg[Q_BITS-1] > Q_SAT))
            coord_next = COORD_MAX;
        else
            coord_next = signed'(quo_reg[Q_BITS-1] - COORD_OFS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_prod;
            den_reg <= (span == 13'd0) ? 13'd1 : span;
            for (int k = 0; k < Q_BITS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                nlo_reg[k] <= nlo_next[k];
                dv_reg[k]  <= dv_next[k];
            end
            ovf_reg   <= ovf_next;
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

>>> sv/ppg_sine.sv
`timescale 1ns / 1ps

module ppg_sine
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic                                 turn_mode,
    input  logic signed [ppg_pkg::PH_W-1:0]      phase,
    input  logic [31:0]                          offset,
    output logic signed [ppg_pkg::SINE_W-1:0]    sine
);
    import ppg_pkg::*;

    localparam logic [SIN_ABITS:0] DEPTH_V = SIN_DEPTH[SIN_ABITS:0];

    logic [47:0]          ph_ext;
    logic [30:0]          hi_prod;
    logic [46:0]          lo_prod;
    logic [30:0]          m_hi_reg;
    logic [46:0]          m_lo_reg;
    logic [31:0]          raw_reg;
    logic [31:0]          ofs_reg;
    logic                 mode_reg;
    logic [47:0]          m_sum;
    logic [31:0]          turn_next;
    logic [31:0]          turn_reg;
    logic [SIN_ABITS-1:0] pos;
    logic [SIN_ABITS:0]   idx_next;
    logic [SIN_ABITS:0]   idx_reg;
    logic                 neg_reg;
    logic                 neg2_reg;
    logic [16:0]          mag_reg;

    // Radians to turns, kept modulo 2^48 and split in two partial products
    assign ph_ext  = 48'(phase);
    assign hi_prod = 31'(ph_ext[47:17] * INV_2PI_Q32);
    assign lo_prod = 47'(ph_ext[16:0]) * 47'(INV_2PI_Q32);

    assign m_sum     = {m_hi_reg, 17'b0} + {1'b0, m_lo_reg};
    assign turn_next = (mode_reg ? raw_reg : m_sum[47:16]) + ofs_reg;

    // Mirror the index in odd quadrants
    assign pos      = turn_reg[29 -: SIN_ABITS];
    assign idx_next = turn_reg[30] ? (DEPTH_V - {1'b0, pos}) : {1'b0, pos};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_hi_reg <= hi_prod;
            m_lo_reg <= lo_prod;
            raw_reg  <= phase[31:0];
            ofs_reg  <= offset;
            mode_reg <= turn_mode;
            turn_reg <= turn_next;
            idx_reg  <= idx_next;
            neg_reg  <= turn_reg[31];
            mag_reg  <= SIN_TAB[idx_reg];
            neg2_reg <= neg_reg;
        end
    end

    assign sine = neg2_reg ? -signed'({1'b0, mag_reg}) : signed'({1'b0, mag_reg});

endmodule

>>> sv/ppg_isqrt.sv
`timescale 1ns / 1ps

module ppg_isqrt
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [ppg_pkg::SQ_W-1:0]      value,
    output logic [ppg_pkg::ROOT_W-1:0]    root
);
    import ppg_pkg::*;

    logic [SQ_W-1:0] v_reg  [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_reg  [0:SQ_STEPS-1];
    logic [SQ_W-1:0] v_next [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_next [0:SQ_STEPS-1];

    // One result bit per stage, trial bit moving down two places each step
    always_comb
    begin
        logic [SQ_W-1:0] v_i;
        logic [SQ_W-1:0] r_i;
        logic [SQ_W-1:0] bit_k;
        logic [SQ_W-1:0] rb;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                v_i = value;
                r_i = '0;
            end
            else
            begin
                v_i = v_reg[k-1];
                r_i = r_reg[k-1];
            end
            bit_k = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            rb = r_i + bit_k;
            if (v_i >= rb)
            begin
                v_next[k] = v_i - rb;
                r_next[k] = (r_i >> 1) + bit_k;
            end
            else
            begin
                v_next[k] = v_i;
                r_next[k] = r_i >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

>>> sv/plasma_pixel_generator_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload (low bit first)                      Handshake
// s_axis    in   column[11:0] row[23:12] frame_time[55:24]     tvalid/tready
// m_axis    out  pixel_index[23:0] red green blue [47:24]      tvalid/tready
// cfg       in   cfg_index (register), cfg_data (value)        cfg_valid/cfg_ready
//
// One pixel request per clock while the output is not stalled.
// The latency is set by the coordinate divider (24 quotient steps) and the
// two square root chains (24 steps each), plus four-stage sine units.
// Reset clears valid bits and sets the configuration to its defaults; no table fill or clearing pass.
// A stall at the output freezes every stage together; nothing is lost or repeated.
// Configuration writes are always taken; cfg_ready stays high.

module plasma_pixel_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // column, row, frame_time
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pixel_index, red, green, blue
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ppg_pkg::*;

    // Stage numbers counted in enabled cycles after the request is taken
    localparam int T_XY   = L_DIV;
    localparam int T_PH1  = T_XY + 1;
    localparam int T_S1   = T_PH1 + L_SIN;
    localparam int T_MIX  = T_S1 + 1;
    localparam int T_SQ   = T_MIX + 1;
    localparam int T_SUM  = T_SQ + 1;
    localparam int T_ROOT = T_SUM + L_SQRT;
    localparam int T_PH2  = T_ROOT + 1;
    localparam int T_S2   = T_PH2 + L_SIN;
    localparam int T_VAL  = T_S2 + 1;
    localparam int T_S3   = T_VAL + L_SIN;
    localparam int T_OUT  = T_S3 + 1;

    // Configuration
    logic [12:0]        frame_width_reg;
    logic [12:0]        frame_height_reg;
    logic               interactive_reg;
    logic signed [15:0] pointer_x_reg;
    logic signed [15:0] pointer_y_reg;

    // Control
    logic [T_OUT:1] valid_reg;
    logic           adv;

    // Request fields
    logic [11:0] col_in;
    logic [11:0] row_in;
    logic [31:0] t_in;
    logic [46:0] t33_prod;
    logic [24:0] pidx_prod;

    // Delay lines
    logic [31:0]        t_pipe_reg    [1:T_ROOT];
    logic [31:0]        t33_pipe_reg  [1:T_ROOT];
    logic [23:0]        pidx_pipe_reg [1:T_S3];
    logic signed [23:0] x_pipe_reg    [T_PH1:T_S1];
    logic signed [23:0] y_pipe_reg    [T_PH1:T_S1];
    logic signed [19:0] sum_pipe_reg  [T_MIX:T_S2];

    // Coordinates
    logic signed [23:0] x_div;
    logic signed [23:0] y_div;

    // First sine group
    logic signed [PH_W-1:0]   ph_a_next [0:4];
    logic signed [PH_W-1:0]   ph_a_reg  [0:4];
    logic signed [SINE_W-1:0] s_a       [0:4];
    logic signed [PH_W-1:0]   t26_s;
    logic signed [PH_W-1:0]   x34;
    logic signed [PH_W-1:0]   y34;

    // Moving centre and pointer distance
    logic signed [24:0] cx_reg;
    logic signed [24:0] cy_reg;
    logic signed [24:0] dx_reg;
    logic signed [24:0] dy_reg;
    logic signed [49:0] cx2_full;
    logic signed [49:0] cy2_full;
    logic signed [49:0] dx2_full;
    logic signed [49:0] dy2_full;
    logic [SQ_W-1:0]    cx2_reg;
    logic [SQ_W-1:0]    cy2_reg;
    logic [SQ_W-1:0]    dx2_reg;
    logic [SQ_W-1:0]    dy2_reg;
    logic [SQ_W-1:0]    sq_root_reg;
    logic [SQ_W-1:0]    sq_dist_reg;
    logic [ROOT_W-1:0]  root;
    logic [ROOT_W-1:0]  ptr_dist;

    // Second sine group
    logic signed [PH_W-1:0]   ph_b_next [0:2];
    logic signed [PH_W-1:0]   ph_b_reg  [0:2];
    logic signed [SINE_W-1:0] s_b       [0:2];
    logic signed [PH_W-1:0]   t58_s;

    // Colour sines
    logic signed [21:0]       val_s;
    logic signed [21:0]       vr_s;
    logic signed [21:0]       vb_s;
    logic signed [PH_W-1:0]   ph_c_next [0:2];
    logic signed [PH_W-1:0]   ph_c_reg  [0:2];
    logic signed [SINE_W-1:0] s_c       [0:2];
    logic [7:0]               chan      [0:2];

    logic [47:0] out_data_reg;

    // Hold every stage while the result waits
    assign adv           = ~valid_reg[T_OUT] | m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[T_OUT];
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 13'd128;
            frame_height_reg <= 13'd128;
            interactive_reg  <= 1'b0;
            pointer_x_reg    <= -16'sd2048;
            pointer_y_reg    <= -16'sd2048;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[12:0];
                REG_INTERACTIVE:  interactive_reg  <= cfg_data[0];
                REG_POINTER_X:    pointer_x_reg    <= signed'(cfg_data);
                REG_POINTER_Y:    pointer_y_reg    <= signed'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[T_OUT-1:1], s_axis_tvalid};
    end

    // Request decode
    assign col_in    = s_axis_tdata[11:0] & COORD_MASK;
    assign row_in    = s_axis_tdata[23:12] & COORD_MASK;
    assign t_in      = s_axis_tdata[55:24];
    assign t33_prod  = 47'(t_in) * 47'(T33_MUL);
    assign pidx_prod = 25'(row_in) * 25'(frame_width_reg) + 25'(col_in);

    ppg_div u_div_x
    (
        .clk   (clk),
        .en    (adv),
        .idx   (col_in),
        .span  (frame_width_reg),
        .coord (x_div)
    );

    ppg_div u_div_y
    (
        .clk   (clk),
        .en    (adv),
        .idx   (row_in),
        .span  (frame_height_reg),
        .coord (y_div)
    );

    // Phases of the three waves and the centre motion
    always_comb
    begin
        t26_s = signed'({2'b00, t_pipe_reg[T_XY]});
        x34   = PH_W'(x_div);
        y34   = PH_W'(y_div);
        ph_a_next[0] = y34 + t26_s;
        ph_a_next[1] = (x34 + t26_s) >>> 1;
        ph_a_next[2] = (x34 + y34 + t26_s) >>> 1;
        ph_a_next[3] = signed'({2'b00, t33_pipe_reg[T_XY]});
        ph_a_next[4] = signed'({3'b000, t_pipe_reg[T_XY][31:1]});
    end

    assign cx2_full = 50'(cx_reg) * 50'(cx_reg);
    assign cy2_full = 50'(cy_reg) * 50'(cy_reg);
    assign dx2_full = 50'(dx_reg) * 50'(dx_reg);
    assign dy2_full = 50'(dy_reg) * 50'(dy_reg);

    always_comb
    begin
        t58_s = signed'({2'b00, t_pipe_reg[T_ROOT]});
        ph_b_next[0] = signed'({10'b0, root}) + t58_s;
        ph_b_next[1] = signed'({9'b0, ptr_dist, 1'b0}) + t58_s;
        ph_b_next[2] = signed'({10'b0, ptr_dist}) + signed'({2'b00, t33_pipe_reg[T_ROOT]});
    end

    // Halve the wave sum, then add the pointer terms in interactive mode
    always_comb
    begin
        val_s = (22'(sum_pipe_reg[T_S2]) + 22'(s_b[0])) >>> 1;
        vr_s  = interactive_reg ? (val_s + 22'(s_b[1])) : val_s;
        vb_s  = interactive_reg ? (val_s + 22'(s_b[2])) : val_s;
        ph_c_next[0] = signed'({2'b00, vr_s[16:0], 15'b0});
        ph_c_next[1] = signed'({2'b00, val_s[16:0], 15'b0});
        ph_c_next[2] = signed'({2'b00, vb_s[16:0], 15'b0});
    end

    // Map each colour sine to 0..255
    always_comb
    begin
        logic signed [18:0] u;
        logic [26:0]        prod;
        for (int i = 0; i < 3; i++)
        begin
            u = 19'(s_c[i]) + 19'sd65536;
            prod = 27'(unsigned'(u)) * 27'd255;
            chan[i] = (prod[25:17] > 9'd255) ? 8'd255 : prod[24:17];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_pipe_reg[1]    <= t_in;
            t33_pipe_reg[1]  <= {1'b0, t33_prod[46:16]};
            pidx_pipe_reg[1] <= pidx_prod[23:0];
            for (int k = 2; k <= T_ROOT; k++)
            begin
                t_pipe_reg[k]   <= t_pipe_reg[k-1];
                t33_pipe_reg[k] <= t33_pipe_reg[k-1];
            end
            for (int k = 2; k <= T_S3; k++)
                pidx_pipe_reg[k] <= pidx_pipe_reg[k-1];

            x_pipe_reg[T_PH1] <= x_div;
            y_pipe_reg[T_PH1] <= y_div;
            for (int k = T_PH1 + 1; k <= T_S1; k++)
            begin
                x_pipe_reg[k] <= x_pipe_reg[k-1];
                y_pipe_reg[k] <= y_pipe_reg[k-1];
            end
            for (int i = 0; i < 5; i++)
                ph_a_reg[i] <= ph_a_next[i];

            sum_pipe_reg[T_MIX] <= 20'(s_a[0]) + 20'(s_a[1]) + 20'(s_a[2]);
            for (int k = T_MIX + 1; k <= T_S2; k++)
                sum_pipe_reg[k] <= sum_pipe_reg[k-1];
            cx_reg <= 25'(x_pipe_reg[T_S1]) + 25'(s_a[3]) * 25'sd10;
            cy_reg <= 25'(y_pipe_reg[T_S1]) + 25'(s_a[4]) * 25'sd10;
            dx_reg <= 25'(x_pipe_reg[T_S1]) - 25'(signed'({pointer_x_reg, 4'b0}));
            dy_reg <= 25'(y_pipe_reg[T_S1]) - 25'(signed'({pointer_y_reg, 4'b0}));

            cx2_reg <= cx2_full[SQ_W-1:0];
            cy2_reg <= cy2_full[SQ_W-1:0];
            dx2_reg <= dx2_full[SQ_W-1:0];
            dy2_reg <= dy2_full[SQ_W-1:0];

            sq_root_reg <= cx2_reg + cy2_reg + SQ_BIAS;
            sq_dist_reg <= dx2_reg + dy2_reg;

            for (int i = 0; i < 3; i++)
            begin
                ph_b_reg[i] <= ph_b_next[i];
                ph_c_reg[i] <= ph_c_next[i];
            end

            out_data_reg <= {chan[2], chan[1], chan[0], pidx_pipe_reg[T_S3]};
        end
    end

    genvar g;
    generate
        for (g = 0; g < 5; g++)
        begin : g_sin_a
            ppg_sine u_sine
            (
                .clk       (clk),
                .en        (adv),
                .turn_mode (1'b0),
                .phase     (ph_a_reg[g]),
                .offset    ((g == 4) ? QUARTER_TURN : 32'd0),
                .sine      (s_a[g])
            );
        end
        for (g = 0; g < 3; g++)
        begin : g_sin_b
            ppg_sine u_sine
            (
                .clk       (clk),
                .en        (adv),
                .turn_mode (1'b0),
                .phase     (ph_b_reg[g]),
                .offset    ((g == 2) ? QUARTER_TURN : 32'd0),
                .sine      (s_b[g])
            );
        end
        for (g = 0; g < 3; g++)
        begin : g_sin_c
            ppg_sine u_sine
            (
                .clk       (clk),
                .en        (adv),
                .turn_mode (1'b1),
                .phase     (ph_c_reg[g]),
                .offset    ((g == 1) ? GREEN_TURN : ((g == 2) ? BLUE_TURN : 32'd0)),
                .sine      (s_c[g])
            );
        end
    endgenerate

    ppg_isqrt u_sqrt_root
    (
        .clk   (clk),
        .en    (adv),
        .value (sq_root_reg),
        .root  (root)
    );

    ppg_isqrt u_sqrt_dist
    (
        .clk   (clk),
        .en    (adv),
        .value (sq_dist_reg),
        .root  (ptr_dist)
    );

    // A stall freezes the whole valid line
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("valid line moved during a stall");

    // The first wave's sine magnitude never exceeds one
    a_sine_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[T_S1] |-> (s_a[0] <= 18'sd65536) && (s_a[0] >= -18'sd65536))
        else $error("sine out of range");

    // The centre distance includes a bias of one, so its root is at least one
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[T_ROOT] |-> (root >= ROOT_W'(65536)))
        else $error("square root below its bias");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ppg_pkg::*;

    // Register index that the block has to ignore
    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam int LATENCY = 69;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct
    {
        logic [23:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    typedef struct
    {
        logic [11:0] column;
        logic [11:0] row;
        logic [31:0] frame_time;
        bit          typed;
        logic [23:0] index_typed;
    } pixel_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Shadow copy of the configuration
    logic [12:0] width_shadow;
    logic [12:0] height_shadow;
    logic        mode_shadow;
    longint      ptr_x_shadow;
    longint      ptr_y_shadow;

    longint      sine_q16 [0:SIN_DEPTH];
    pixel_t      pixels_due [$];
    int          errors = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    plasma_pixel_generator_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Quarter-wave table, Q30 Taylor series rounded to Q16
    task automatic fill_sine_table();
        longint unsigned x;
        longint unsigned term;
        longint sum;
        longint r;
        for (int i = 0; i <= SIN_DEPTH; i++)
        begin
            x = (64'd1686629713 * longint'(i)) / SIN_DEPTH;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 8; k++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            r = (sum < 0) ? 0 : ((sum + 8192) >>> 14);
            sine_q16[i] = (r > 65536) ? 65536 : r;
        end
    endtask

    function automatic longint sine_of_turn(logic [31:0] a);
        logic [9:0] p;
        longint mag;
        p = a[29:20];
        mag = a[30] ? sine_q16[SIN_DEPTH - p] : sine_q16[p];
        return a[31] ? -mag : mag;
    endfunction

    function automatic logic [31:0] turn_of_rad(longint ph);
        longint unsigned prod;
        prod = longint'(ph) * 64'd683565276;
        return prod[47:16];
    endfunction

    function automatic logic [31:0] turn_of_half(longint v);
        logic [63:0] w;
        w = v;
        return {w[16:0], 15'd0};
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint scaled_coord(logic [11:0] idx, logic [12:0] span);
        longint unsigned num;
        longint unsigned d;
        longint c;
        num = longint'(idx) * 1310720;
        d = (span == 0) ? 1 : span;
        c = longint'(num / d) - 1310720;
        if (c > 8388607)
            c = 8388607;
        if (c < -8388608)
            c = -8388608;
        return c;
    endfunction

    function automatic logic [7:0] intensity(longint s);
        longint unsigned c;
        c = (longint'(s + 65536) * 255) >> 17;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic pixel_t plasma_pixel(logic [11:0] col, logic [11:0] row,
                                            logic [31:0] ft);
        pixel_t px;
        longint x, y, t, t33, v, cx, cy, root, dx, dy, ptr_dist, rs, gs, bs;
        logic [11:0] c;
        logic [11:0] r;
        logic [63:0] lin;
        c = col & COORD_MASK;
        r = row & COORD_MASK;
        x = scaled_coord(c, width_shadow);
        y = scaled_coord(r, height_shadow);
        t = longint'(ft);
        t33 = (t * 21627) >>> 16;
        v = sine_of_turn(turn_of_rad(y + t));
        v += sine_of_turn(turn_of_rad((x + t) >>> 1));
        v += sine_of_turn(turn_of_rad((x + y + t) >>> 1));
        cx = x + 10 * sine_of_turn(turn_of_rad(t33));
        cy = y + 10 * sine_of_turn(turn_of_rad(t >>> 1) + QUARTER_TURN);
        root = longint'(floor_root(longint'(cx * cx) + longint'(cy * cy) + 64'h1_0000_0000));
        v += sine_of_turn(turn_of_rad(root + t));
        v = v >>> 1;
        gs = sine_of_turn(turn_of_half(v) + GREEN_TURN);
        if (mode_shadow)
        begin
            dx = x - ptr_x_shadow * 16;
            dy = y - ptr_y_shadow * 16;
            ptr_dist = longint'(floor_root(longint'(dx * dx) + longint'(dy * dy)));
            rs = sine_of_turn(turn_of_half(v + sine_of_turn(turn_of_rad(2 * ptr_dist + t))));
            bs = sine_of_turn(turn_of_half(v + sine_of_turn(turn_of_rad(ptr_dist + t33)
                                           + QUARTER_TURN)) + BLUE_TURN);
        end
        else
        begin
            rs = sine_of_turn(turn_of_half(v));
            bs = sine_of_turn(turn_of_half(v) + BLUE_TURN);
        end
        lin = longint'(r) * longint'(width_shadow) + longint'(c);
        px.pixel_index = lin[23:0];
        px.red = intensity(rs);
        px.green = intensity(gs);
        px.blue = intensity(bs);
        return px;
    endfunction

    // Offer one pixel request, in bursts with gaps between them
    task automatic send_pixel(pixel_req_t rq);
        pixel_t px;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                                      : int'($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rq.frame_time, rq.row, rq.column};
        do
            @(posedge clk);
        while (!s_axis_tready);
        px = plasma_pixel(rq.column, rq.row, rq.frame_time);
        if (rq.typed)
            px.pixel_index = rq.index_typed;
        pixels_due.push_back(px);
        burst_left--;
    endtask

    // Drain the pipeline before a register write
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  width_shadow = data[12:0];
            REG_FRAME_HEIGHT: height_shadow = data[12:0];
            REG_INTERACTIVE:  mode_shadow = data[0];
            REG_POINTER_X:    ptr_x_shadow = longint'(signed'(data));
            REG_POINTER_Y:    ptr_y_shadow = longint'(signed'(data));
            default:          ;
        endcase
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h, logic m,
                             logic [15:0] px, logic [15:0] py);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_INTERACTIVE, {15'd0, m});
        write_reg(REG_POINTER_X, px);
        write_reg(REG_POINTER_Y, py);
    endtask

    function automatic pixel_req_t req_of(logic [11:0] c, logic [11:0] r, logic [31:0] t);
        pixel_req_t rq;
        rq.column = c;
        rq.row = r;
        rq.frame_time = t;
        rq.typed = 1'b0;
        rq.index_typed = '0;
        return rq;
    endfunction

    function automatic pixel_req_t random_req();
        logic [11:0] c;
        logic [11:0] r;
        int w;
        int h;
        w = (width_shadow == 0) ? 1 : int'(width_shadow);
        h = (height_shadow == 0) ? 1 : int'(height_shadow);
        if ($urandom_range(0, 4) == 0)
        begin
            c = 12'($urandom);
            r = 12'($urandom);
        end
        else
        begin
            c = 12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
            r = 12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
        end
        return req_of(c, r, $urandom);
    endfunction

    // Directed requests after reset: 128 by 128, pointer mode off
    pixel_req_t reset_rows [] = '{
        '{12'd0,    12'd0,    32'h0000_0000, 1'b1, 24'd0},
        '{12'd127,  12'd127,  32'h0000_0000, 1'b1, 24'd16383},
        '{12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, 24'd528255},
        '{12'd4095, 12'd0,    32'h0000_0000, 1'b1, 24'd4095},
        '{12'd0,    12'd4095, 32'h1234_5678, 1'b1, 24'd524160},
        '{12'd64,   12'd64,   32'h0000_8000, 1'b0, 24'd0},
        '{12'd1,    12'd2,    32'hFFFF_0000, 1'b1, 24'd257},
        '{12'd2730, 12'd1365, 32'h5555_AAAA, 1'b0, 24'd0},
        '{12'd1365, 12'd2730, 32'hAAAA_5555, 1'b0, 24'd0}
    };

    // Receiver: random stall patterns, and one long hold-off on request
    initial
    begin
        int style;
        int left;
        style = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (left == 0)
            begin
                style = $urandom_range(0, 3);
                left = $urandom_range(20, 100);
            end
            left--;
            case (style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // Compare each accepted pixel with the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pixels_due.size() == 0)
            begin
                $display("%0t: unexpected pixel, actual %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pixels_due.pop_front();
                if (m_axis_tdata[23:0] !== want.pixel_index)
                begin
                    $display("%0t: pixel_index expected %0d actual %0d", $time,
                             want.pixel_index, m_axis_tdata[23:0]);
                    errors++;
                end
                if (m_axis_tdata[31:24] !== want.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time,
                             want.red, m_axis_tdata[31:24]);
                    errors++;
                end
                if (m_axis_tdata[39:32] !== want.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time,
                             want.green, m_axis_tdata[39:32]);
                    errors++;
                end
                if (m_axis_tdata[47:40] !== want.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time,
                             want.blue, m_axis_tdata[47:40]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no handshake anywhere
    always @(posedge clk)
    begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        width_shadow = 13'd128;
        height_shadow = 13'd128;
        mode_shadow = 1'b0;
        ptr_x_shadow = -2048;
        ptr_y_shadow = -2048;
        fill_sine_table();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (reset_rows[i])
            send_pixel(reset_rows[i]);

        // Largest frame: index reaches its maximum at the top corner
        set_frame(16'd4096, 16'd4096, 1'b1, 16'h8000, 16'h7FFF);
        send_pixel('{12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, 24'd16777215});
        send_pixel('{12'd0, 12'd0, 32'h0000_0000, 1'b1, 24'd0});
        send_pixel(req_of(12'd2048, 12'd2048, 32'h8000_0000));

        // One pixel frame: coordinates saturate
        set_frame(16'd1, 16'd1, 1'b1, 16'h7FFF, 16'h8000);
        send_pixel('{12'd4095, 12'd4095, 32'h0001_0000, 1'b1, 24'd8190});
        send_pixel(req_of(12'd0, 12'd0, 32'hFFFF_FFFF));

        // Zero divisor: stride zero, index equals column
        set_frame(16'd0, 16'd0, 1'b0, 16'd0, 16'd0);
        send_pixel('{12'd4095, 12'd4095, 32'h0000_0000, 1'b1, 24'd4095});
        send_pixel('{12'd17, 12'd99, 32'h0003_0000, 1'b1, 24'd17});

        // Out-of-range width field, and a write to an index that does not exist
        set_frame(16'h1FFF, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pixel(req_of(12'd4095, 12'd4095, 32'h0000_FFFF));
        send_pixel(req_of(12'd100, 12'd3000, 32'h7FFF_FFFF));

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_frame(16'd128, 16'd96, 1'b0, 16'hF800, 16'hF800);
                1: set_frame(16'd4096, 16'd4096, 1'b1, 16'($urandom), 16'($urandom));
                2: set_frame(16'd1, 16'd4096, 1'b1, 16'h8000, 16'h8000);
                default: set_frame(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)),
                                   1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
            endcase
            if (phase == 1)
                hold_req = 1'b1;
            repeat (205) send_pixel(random_req());
        end

        drain();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
sv/ppg_pkg.sv
sv/ppg_div.sv
sv/ppg_sine.sv
sv/ppg_isqrt.sv
sv/plasma_pixel_generator_top.sv
tb/sv/testbench.sv
